[hdl/cau_pkg.sv]
// ---------------------------------------------------------------------------
// cau_pkg
// Shared widths, mode codes, stage records and saturation for the complex
// arithmetic unit.
// ---------------------------------------------------------------------------
package cau_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W        = 32;
   localparam int MODE_W        = 2;
   localparam int PROD_W        = 64;
   localparam int SUM_W         = PROD_W + 1;
   localparam int MAG_W         = 64;
   localparam int QUO_W         = 32;
   localparam int SAT_W         = MAG_W + 1;
   localparam int FRONT_LAT     = 3;
   localparam int DIV_LAT       = QUO_W + 2;

   localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SUB = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MUL = 2'd2;
   localparam logic [MODE_W-1:0] MODE_DIV = 2'd3;

   localparam logic [SAT_W-1:0] SAT_POS = 65'h0_7FFF_FFFF;
   localparam logic [SAT_W-1:0] SAT_NEG = 65'h0_8000_0000;

   typedef struct packed {
      logic              ovf;
      logic [DATA_W-1:0] value;
   } sat_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [DATA_W-1:0] as_re;
      logic [DATA_W-1:0] as_im;
      logic              as_ovf;
      logic              re_neg;
      logic [MAG_W-1:0]  re_mag;
      logic              im_neg;
      logic [MAG_W-1:0]  im_mag;
      logic [MAG_W-1:0]  den;
      logic              den_zero;
   } front_out_type;

   typedef struct packed {
      logic              is_div;
      logic              dbz;
      logic [DATA_W-1:0] re;
      logic [DATA_W-1:0] im;
      logic              ovf;
   } side_type;

   typedef struct packed {
      logic [MAG_W-1:0] rem;
      logic [QUO_W-1:0] low;
      logic [QUO_W-1:0] quo;
      logic [MAG_W-1:0] den;
      logic             neg;
      logic             big;
   } div_state_type;

   typedef struct packed {
      logic [DATA_W-1:0] re;
      logic [DATA_W-1:0] im;
      logic              ovf;
      logic              dbz;
   } rsp_type;

   // Clamp a sign and magnitude pair to 32-bit two's complement.
   function automatic sat_type sat_sm(input logic neg, input logic [SAT_W-1:0] mag);
      sat_type          r;
      logic [SAT_W-1:0] lim;
      logic [SAT_W-1:0] m;
      lim     = neg ? SAT_NEG : SAT_POS;
      r.ovf   = (mag > lim);
      m       = r.ovf ? lim : mag;
      r.value = neg ? (DATA_W'(0) - m[DATA_W-1:0]) : m[DATA_W-1:0];
      return r;
   endfunction

endpackage

[hdl/cau_if.sv]
// ---------------------------------------------------------------------------
// cau_if
// Valid/ready channels of the complex arithmetic unit: operand request and
// result response.
// ---------------------------------------------------------------------------
interface cau_req_if import cau_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic signed [DATA_W-1:0] first_real;
   logic signed [DATA_W-1:0] first_imag;
   logic signed [DATA_W-1:0] second_real;
   logic signed [DATA_W-1:0] second_imag;

   modport source (output valid, mode, first_real, first_imag, second_real, second_imag,
                   input ready);
   modport sink   (input valid, mode, first_real, first_imag, second_real, second_imag,
                   output ready);
endinterface

interface cau_rsp_if import cau_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] result_real;
   logic signed [DATA_W-1:0] result_imag;
   logic                     overflow;
   logic                     divide_by_zero;

   modport source (output valid, result_real, result_imag, overflow, divide_by_zero,
                   input ready);
   modport sink   (input valid, result_real, result_imag, overflow, divide_by_zero,
                   output ready);
endinterface

[hdl/cau_front.sv]
// ---------------------------------------------------------------------------
// cau_front
// Three-stage front end: partial products and add/subtract, sums of
// products and divisor, then sign and magnitude.
// ---------------------------------------------------------------------------
module cau_front import cau_pkg::*; (
   input  logic                     clock,
   input  logic                     en,
   input  logic [MODE_W-1:0]        mode,
   input  logic signed [DATA_W-1:0] first_real,
   input  logic signed [DATA_W-1:0] first_imag,
   input  logic signed [DATA_W-1:0] second_real,
   input  logic signed [DATA_W-1:0] second_imag,
   output front_out_type            out_ff
);

   // stage 1
   logic signed [PROD_W-1:0] aa_in, bb_in, ab_in, ba_in;
   logic signed [PROD_W-1:0] aa_ff, bb_ff, ab_ff, ba_ff;
   logic [PROD_W-1:0]        a2sq_in, b2sq_in, a2sq_ff, b2sq_ff;
   logic signed [DATA_W:0]   sre, sim;
   logic [DATA_W-1:0]        as_re_in, as_im_in, as_re1_ff, as_im1_ff;
   logic                     as_ovf_in, as_ovf1_ff;
   logic [MODE_W-1:0]        mode1_ff;

   // stage 2
   logic signed [SUM_W-1:0]  s_re_in, s_im_in, s_re_ff, s_im_ff;
   logic [MAG_W-1:0]         den_in, den_ff;
   logic [DATA_W-1:0]        as_re2_ff, as_im2_ff;
   logic                     as_ovf2_ff;
   logic [MODE_W-1:0]        mode2_ff;

   // stage 3
   logic [SUM_W-1:0]         re_abs, im_abs;
   front_out_type            out_in;

   assign aa_in   = PROD_W'(first_real) * PROD_W'(second_real);
   assign bb_in   = PROD_W'(first_imag) * PROD_W'(second_imag);
   assign ab_in   = PROD_W'(first_real) * PROD_W'(second_imag);
   assign ba_in   = PROD_W'(second_real) * PROD_W'(first_imag);
   assign a2sq_in = $unsigned(PROD_W'(second_real) * PROD_W'(second_real));
   assign b2sq_in = $unsigned(PROD_W'(second_imag) * PROD_W'(second_imag));

   always_comb begin
      if (mode == MODE_SUB) begin
         sre = (DATA_W+1)'(first_real) - (DATA_W+1)'(second_real);
         sim = (DATA_W+1)'(first_imag) - (DATA_W+1)'(second_imag);
      end else begin
         sre = (DATA_W+1)'(first_real) + (DATA_W+1)'(second_real);
         sim = (DATA_W+1)'(first_imag) + (DATA_W+1)'(second_imag);
      end
      as_ovf_in = (sre[DATA_W] != sre[DATA_W-1]) || (sim[DATA_W] != sim[DATA_W-1]);
      if (sre[DATA_W] != sre[DATA_W-1]) begin
         as_re_in = sre[DATA_W] ? SAT_NEG[DATA_W-1:0] : SAT_POS[DATA_W-1:0];
      end else begin
         as_re_in = sre[DATA_W-1:0];
      end
      if (sim[DATA_W] != sim[DATA_W-1]) begin
         as_im_in = sim[DATA_W] ? SAT_NEG[DATA_W-1:0] : SAT_POS[DATA_W-1:0];
      end else begin
         as_im_in = sim[DATA_W-1:0];
      end
   end

   // product mode: a1a2 - b1b2, a1b2 + a2b1; quotient mode numerators: a1a2 + b1b2, a2b1 - a1b2
   always_comb begin
      if (mode1_ff == MODE_MUL) begin
         s_re_in = SUM_W'(aa_ff) - SUM_W'(bb_ff);
         s_im_in = SUM_W'(ab_ff) + SUM_W'(ba_ff);
      end else begin
         s_re_in = SUM_W'(aa_ff) + SUM_W'(bb_ff);
         s_im_in = SUM_W'(ba_ff) - SUM_W'(ab_ff);
      end
      den_in = a2sq_ff + b2sq_ff;
   end

   always_comb begin
      re_abs          = s_re_ff[SUM_W-1] ? -s_re_ff : s_re_ff;
      im_abs          = s_im_ff[SUM_W-1] ? -s_im_ff : s_im_ff;
      out_in.mode     = mode2_ff;
      out_in.as_re    = as_re2_ff;
      out_in.as_im    = as_im2_ff;
      out_in.as_ovf   = as_ovf2_ff;
      out_in.re_neg   = s_re_ff[SUM_W-1];
      out_in.re_mag   = re_abs[MAG_W-1:0];
      out_in.im_neg   = s_im_ff[SUM_W-1];
      out_in.im_mag   = im_abs[MAG_W-1:0];
      out_in.den      = den_ff;
      out_in.den_zero = (den_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         aa_ff      <= aa_in;
         bb_ff      <= bb_in;
         ab_ff      <= ab_in;
         ba_ff      <= ba_in;
         a2sq_ff    <= a2sq_in;
         b2sq_ff    <= b2sq_in;
         as_re1_ff  <= as_re_in;
         as_im1_ff  <= as_im_in;
         as_ovf1_ff <= as_ovf_in;
         mode1_ff   <= mode;
         s_re_ff    <= s_re_in;
         s_im_ff    <= s_im_in;
         den_ff     <= den_in;
         as_re2_ff  <= as_re1_ff;
         as_im2_ff  <= as_im1_ff;
         as_ovf2_ff <= as_ovf1_ff;
         mode2_ff   <= mode1_ff;
         out_ff     <= out_in;
      end
   end

endmodule

[hdl/cau_div_stage.sv]
// ---------------------------------------------------------------------------
// cau_div_stage
// One restoring division step: shift in a numerator bit, trial subtract,
// record one quotient bit.
// ---------------------------------------------------------------------------
module cau_div_stage import cau_pkg::*; (
   input  logic          clock,
   input  logic          en,
   input  div_state_type cur,
   output div_state_type state_ff
);

   logic [MAG_W:0]   trial;
   logic [MAG_W:0]   diff;
   logic             ge;
   div_state_type    state_in;

   always_comb begin
      trial          = {cur.rem, cur.low[QUO_W-1]};
      diff           = trial - {1'b0, cur.den};
      ge             = (trial >= {1'b0, cur.den});
      state_in       = cur;
      state_in.rem   = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
      state_in.low   = {cur.low[QUO_W-2:0], 1'b0};
      state_in.quo   = {cur.quo[QUO_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/cau_div_lane.sv]
// ---------------------------------------------------------------------------
// cau_div_lane
// Pipelined fixed-point divider for one result part: range check, one
// quotient bit per stage, then round half away from zero and saturate.
// ---------------------------------------------------------------------------
module cau_div_lane import cau_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             en,
   input  logic             neg,
   input  logic [MAG_W-1:0] mag,
   input  logic [MAG_W-1:0] den,
   output sat_type          res_ff
);

   localparam int NUM_W = MAG_W + FRAC_BITS;

   logic [NUM_W-1:0] num;
   logic [MAG_W-1:0] head;
   div_state_type    entry_in;
   div_state_type    stage_ff [QUO_W+1];
   div_state_type    last;
   logic             up;
   logic [QUO_W:0]   q_rnd;
   logic [SAT_W-1:0] mag_fin;
   sat_type          res_in;

   always_comb begin
      num          = NUM_W'(mag) << FRAC_BITS;
      head         = MAG_W'(num[NUM_W-1:QUO_W]);
      entry_in.rem = head;
      entry_in.low = num[QUO_W-1:0];
      entry_in.quo = '0;
      entry_in.den = den;
      entry_in.neg = neg;
      // quotient needs more than QUO_W bits: saturates for certain
      entry_in.big = (head >= den);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff[0] <= entry_in;
      end
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      cau_div_stage u_step (
         .clock    (clock),
         .en       (en),
         .cur      (stage_ff[k]),
         .state_ff (stage_ff[k+1])
      );
   end

   always_comb begin
      last    = stage_ff[QUO_W];
      up      = ({last.rem, 1'b0} >= {1'b0, last.den});
      q_rnd   = (QUO_W+1)'(last.quo) + (QUO_W+1)'(up);
      mag_fin = last.big ? (SAT_W'(1) << QUO_W) : SAT_W'(q_rnd);
      res_in  = sat_sm(last.neg, mag_fin);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

endmodule

[hdl/complex_arithmetic_unit.sv]
// ---------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply and divide on signed fixed point operands.
// ---------------------------------------------------------------------------
// Usage:
//   req_bus carries a mode and two complex operands; rsp_bus returns one
//   result transaction per request transaction, in order, with saturated
//   parts, an overflow flag and a divide-by-zero flag.
//   Every mode takes the same path from request to response; the block
//   accepts one transaction per cycle while rsp_bus.ready is high or no
//   result waits. The depth is set by the divider: one range check stage,
//   32 restoring steps (one quotient bit each) and a rounding stage, behind
//   three front stages (products, sums, magnitudes), then the output register.
//   Reset clears all valid bits; the pipeline is empty afterwards and
//   req_bus.ready is high.
//   When the receiver holds rsp_bus.ready low with a result waiting, the
//   whole pipeline holds and req_bus.ready drops; nothing is lost or
//   repeated, and the pipeline moves again as soon as the result is taken.
// ---------------------------------------------------------------------------
module complex_arithmetic_unit import cau_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   cau_req_if.sink   req_bus,
   cau_rsp_if.source rsp_bus
);

   localparam int LAT = FRONT_LAT + DIV_LAT + 1;
   localparam logic [SAT_W-1:0] MUL_RND =
      (FRAC_BITS > 0) ? (SAT_W'(1) << (FRAC_BITS - 1)) : '0;

   logic             advance;
   logic [LAT-1:0]   valid_ff;
   front_out_type    fout;
   logic [SAT_W-1:0] re_rnd, im_rnd;
   sat_type          mul_re, mul_im;
   side_type         side_in;
   side_type         side_ff [DIV_LAT];
   side_type         side_last;
   sat_type          div_re, div_im;
   rsp_type          out_in, out_ff;

   // hold every stage while the output transaction waits
   assign advance       = !valid_ff[LAT-1] || rsp_bus.ready;
   assign req_bus.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[LAT-2:0], req_bus.valid};
      end
   end

   cau_front u_front (
      .clock       (clock),
      .en          (advance),
      .mode        (req_bus.mode),
      .first_real  (req_bus.first_real),
      .first_imag  (req_bus.first_imag),
      .second_real (req_bus.second_real),
      .second_imag (req_bus.second_imag),
      .out_ff      (fout)
   );

   // product: round half away from zero on the magnitude, then clamp
   always_comb begin
      re_rnd = ({1'b0, fout.re_mag} + MUL_RND) >> FRAC_BITS;
      im_rnd = ({1'b0, fout.im_mag} + MUL_RND) >> FRAC_BITS;
      mul_re = sat_sm(fout.re_neg, re_rnd);
      mul_im = sat_sm(fout.im_neg, im_rnd);
      side_in.is_div = (fout.mode == MODE_DIV);
      side_in.dbz    = fout.den_zero;
      if (fout.mode == MODE_MUL) begin
         side_in.re  = mul_re.value;
         side_in.im  = mul_im.value;
         side_in.ovf = mul_re.ovf || mul_im.ovf;
      end else begin
         side_in.re  = fout.as_re;
         side_in.im  = fout.as_im;
         side_in.ovf = fout.as_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < DIV_LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   cau_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_re (
      .clock  (clock),
      .en     (advance),
      .neg    (fout.re_neg),
      .mag    (fout.re_mag),
      .den    (fout.den),
      .res_ff (div_re)
   );

   cau_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_im (
      .clock  (clock),
      .en     (advance),
      .neg    (fout.im_neg),
      .mag    (fout.im_mag),
      .den    (fout.den),
      .res_ff (div_im)
   );

   always_comb begin
      side_last = side_ff[DIV_LAT-1];
      if (!side_last.is_div) begin
         out_in.re  = side_last.re;
         out_in.im  = side_last.im;
         out_in.ovf = side_last.ovf;
         out_in.dbz = 1'b0;
      end else if (side_last.dbz) begin
         out_in.re  = '0;
         out_in.im  = '0;
         out_in.ovf = 1'b0;
         out_in.dbz = 1'b1;
      end else begin
         out_in.re  = div_re.value;
         out_in.im  = div_im.value;
         out_in.ovf = div_re.ovf || div_im.ovf;
         out_in.dbz = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid          = valid_ff[LAT-1];
   assign rsp_bus.result_real    = out_ff.re;
   assign rsp_bus.result_imag    = out_ff.im;
   assign rsp_bus.overflow       = out_ff.ovf;
   assign rsp_bus.divide_by_zero = out_ff.dbz;

endmodule

[hdl/cau_checker.sv]
// ---------------------------------------------------------------------------
// cau_checker
// Port-level checks of the complex arithmetic unit, bound to the top level.
// ---------------------------------------------------------------------------
module cau_checker import cau_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] rsp_real,
   input logic [DATA_W-1:0] rsp_imag,
   input logic              rsp_ovf,
   input logic              rsp_dbz
);

   localparam logic [DATA_W-1:0] MAX_V = SAT_POS[DATA_W-1:0];
   localparam logic [DATA_W-1:0] MIN_V = SAT_NEG[DATA_W-1:0];

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request side stalled with an empty output stage");

   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dbz |-> rsp_real == '0 && rsp_imag == '0 && !rsp_ovf)
      else $error("divide by zero result not cleared");

   a_ovf_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ovf |->
         rsp_real == MAX_V || rsp_real == MIN_V || rsp_imag == MAX_V || rsp_imag == MIN_V)
      else $error("overflow flagged without a clamped part");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_real) && $stable(rsp_imag))
      else $error("stalled response transaction changed");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_real  (rsp_bus.result_real),
   .rsp_imag  (rsp_bus.result_imag),
   .rsp_ovf   (rsp_bus.overflow),
   .rsp_dbz   (rsp_bus.divide_by_zero)
);
